// ===== rtl/haptic_pulse_pattern_sequencer_core_macros.svh =====
// Assertion macros for the haptic pulse pattern sequencer
`ifndef HAPTIC_PULSE_PATTERN_SEQUENCER_CORE_MACROS_SVH
`define HAPTIC_PULSE_PATTERN_SEQUENCER_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define HPPS_ASSERT_NOW(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("hpps: same-cycle check failed");

// next-cycle implication, held off during reset
`define HPPS_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("hpps: next-cycle check failed");

`endif

// ===== rtl/hpps_pkg.sv =====
// Types, constants and helpers shared by the haptic pulse pattern sequencer
`default_nettype none

package hpps_pkg;

  localparam int unsigned MsWidth = 16;
  localparam int unsigned IdWidth = 31;
  localparam int unsigned CntWidth = 4;

  localparam logic [31:0] MsMax = (32'd1 << MsWidth) - 32'd1;
  localparam logic [15:0] MinMs = 16'd50;
  localparam logic [IdWidth-1:0] IdMax = {IdWidth{1'b1}};
  localparam logic [CntWidth-1:0] DivLast = {CntWidth{1'b1}};

  typedef enum logic [1:0] {
    OpVibrate = 2'd0,
    OpCancel  = 2'd1,
    OpTick    = 2'd2
  } op_e;

  localparam logic [2:0] EffFree    = 3'd0;
  localparam logic [2:0] EffTapUp   = 3'd1;
  localparam logic [2:0] EffTapDown = 3'd2;
  localparam logic [2:0] EffNotify  = 3'd3;
  localparam logic [2:0] EffAlert   = 3'd4;
  localparam logic [2:0] EffRing    = 3'd5;

  localparam logic [2:0] CfgTapMs       = 3'd0;
  localparam logic [2:0] CfgNotifyMs    = 3'd1;
  localparam logic [2:0] CfgAlertPulses = 3'd2;
  localparam logic [2:0] CfgAlertOnMs   = 3'd3;
  localparam logic [2:0] CfgAlertOffMs  = 3'd4;
  localparam logic [2:0] CfgRingPulses  = 3'd5;
  localparam logic [2:0] CfgRingOnMs    = 3'd6;
  localparam logic [2:0] CfgRingOffMs   = 3'd7;

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhShot = 2'd1,
    PhOn   = 2'd2,
    PhOff  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    SqIdle = 2'd0,
    SqDiv  = 2'd1,
    SqExec = 2'd2
  } seq_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  effect_type;
    logic [15:0] duration_ms;
    logic [15:0] period_ms;
  } in_item_t;

  typedef struct packed {
    logic               motor_on;
    logic               status;
    logic [IdWidth-1:0] effect_id;
    logic               pattern_active;
  } out_item_t;

  // clamp a 16-bit time to the largest value the timers hold
  function automatic logic [MsWidth-1:0] sat_ms(input logic [15:0] v);
    logic [31:0] w;
    w = {16'd0, v};
    if (w > MsMax) begin
      w = MsMax;
    end
    return w[MsWidth-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/haptic_pulse_pattern_sequencer_core.sv =====
`default_nettype none
// Haptic pulse pattern sequencer: motor enable from vibrate, cancel and tick items
//
// Usage: items arrive on in_valid_i/in_ready_o with in_item_i (vibrate request,
// cancel or 1 ms tick); each item yields exactly one result on out_valid_o /
// out_ready_i carrying motor level, status, latest effect id and pattern flag.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i,
// one register per cycle, with no wait; write them only while the block is idle.
// A cancel, tick or non-free-form request passes from acceptance through the
// execute step into the output register; a free-form request with a non-zero
// period first passes through the bit-serial divider (one quotient bit per cycle)
// that works out duration over period. One item is in work at a time; the next
// is accepted once the previous result is in the output register.
// The result sits in an output register, so a new item may be accepted while
// the receiver stalls; that item then holds in its final step until the
// output register is taken.
// Reset: motor off, no pattern, effect id 0, registers at their defaults.

module haptic_pulse_pattern_sequencer_core (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire hpps_pkg::in_item_t    in_item_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output hpps_pkg::out_item_t        out_item_o,
  input  wire                        cfg_we_i,
  input  wire  [2:0]                 cfg_idx_i,
  input  wire  [15:0]                cfg_wdata_i
);
  import hpps_pkg::*;

  // configuration
  logic [15:0] tap_ms_q, notify_ms_q, alert_on_q, alert_off_q, ring_on_q, ring_off_q;
  logic [7:0]  alert_pulses_q, ring_pulses_q;

  // sequencer and item
  seq_e        seq_q, seq_d;
  in_item_t    item_q;
  logic        accept, need_div, div_load, div_run, commit;

  // divider
  logic [15:0]         div_rem_q, div_quo_q;
  logic [CntWidth-1:0] div_cnt_q;
  logic [16:0]         rem_sh;
  logic                div_ge;

  // behavioural state
  phase_e              phase_q, phase_d;
  logic [MsWidth-1:0]  remaining_q, remaining_d, rem_dec;
  logic [15:0]         pulses_left_q, pulses_left_d, pl_dec;
  logic [MsWidth-1:0]  pulse_on_q, pulse_on_d, pulse_off_q, pulse_off_d;
  logic [IdWidth-1:0]  effect_cnt_q, effect_cnt_d;
  logic                status_d;

  // request mapping
  logic [15:0] shot, pulses, on_ms, off_ms, shot_min;
  logic        bump;

  // output register
  logic        out_valid_q;
  out_item_t   out_item_q;

  // ---------------- configuration port ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_ms_q       <= 16'd50;
      notify_ms_q    <= 16'd300;
      alert_pulses_q <= 8'd3;
      alert_on_q     <= 16'd500;
      alert_off_q    <= 16'd500;
      ring_pulses_q  <= 8'd4;
      ring_on_q      <= 16'd800;
      ring_off_q     <= 16'd400;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTapMs:       tap_ms_q       <= cfg_wdata_i;
        CfgNotifyMs:    notify_ms_q    <= cfg_wdata_i;
        CfgAlertPulses: alert_pulses_q <= cfg_wdata_i[7:0];
        CfgAlertOnMs:   alert_on_q     <= cfg_wdata_i;
        CfgAlertOffMs:  alert_off_q    <= cfg_wdata_i;
        CfgRingPulses:  ring_pulses_q  <= cfg_wdata_i[7:0];
        CfgRingOnMs:    ring_on_q      <= cfg_wdata_i;
        CfgRingOffMs:   ring_off_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  assign accept   = in_valid_i && in_ready_o;
  assign need_div = (op_e'(in_item_i.op) == OpVibrate) && (in_item_i.effect_type == EffFree)
                    && (in_item_i.period_ms != 16'd0);

  always_comb begin
    seq_d = seq_q;
    case (seq_q)
      SqIdle: begin
        if (accept) begin
          seq_d = need_div ? SqDiv : SqExec;
        end
      end
      SqDiv: begin
        if (div_cnt_q == DivLast) begin
          seq_d = SqExec;
        end
      end
      SqExec: begin
        if (!out_valid_q || out_ready_i) begin
          seq_d = SqIdle;
        end
      end
      default: seq_d = SqIdle;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    div_load   = 1'b0;
    div_run    = 1'b0;
    commit     = 1'b0;
    case (seq_q)
      SqIdle: begin
        in_ready_o = 1'b1;
        div_load   = accept;
      end
      SqDiv:  div_run = 1'b1;
      SqExec: commit  = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= SqIdle;
    end else begin
      seq_q <= seq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  // ---------------- restoring divider, one quotient bit a cycle ----------------
  assign rem_sh = {div_rem_q, div_quo_q[15]};
  assign div_ge = rem_sh >= {1'b0, item_q.period_ms};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (div_load) begin
      div_cnt_q <= '0;
    end else if (div_run) begin
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_load) begin
      div_rem_q <= '0;
      div_quo_q <= in_item_i.duration_ms;
    end else if (div_run) begin
      div_rem_q <= div_ge ? 16'(rem_sh - {1'b0, item_q.period_ms}) : rem_sh[15:0];
      div_quo_q <= {div_quo_q[14:0], div_ge};
    end
  end

  // ---------------- item execution ----------------
  always_comb begin
    shot   = '0;
    pulses = '0;
    on_ms  = '0;
    off_ms = '0;
    case (item_q.effect_type)
      EffFree: begin
        if (item_q.period_ms != 16'd0) begin
          pulses = div_quo_q;
          on_ms  = {1'b0, item_q.period_ms[15:1]};
          off_ms = {1'b0, item_q.period_ms[15:1]};
          if (div_quo_q == 16'd0) begin
            shot = item_q.duration_ms;
          end
        end else begin
          shot = item_q.duration_ms;
        end
      end
      EffTapUp, EffTapDown: shot = tap_ms_q;
      EffNotify:            shot = notify_ms_q;
      EffAlert: begin
        pulses = {8'd0, alert_pulses_q};
        on_ms  = alert_on_q;
        off_ms = alert_off_q;
      end
      EffRing: begin
        pulses = {8'd0, ring_pulses_q};
        on_ms  = ring_on_q;
        off_ms = ring_off_q;
      end
      default: ;
    endcase
  end

  assign shot_min = (shot < MinMs) ? MinMs : shot;
  assign rem_dec  = (remaining_q != '0) ? remaining_q - 1'b1 : remaining_q;
  assign pl_dec   = (pulses_left_q != 16'd0) ? pulses_left_q - 16'd1 : pulses_left_q;

  always_comb begin
    phase_d       = phase_q;
    remaining_d   = remaining_q;
    pulses_left_d = pulses_left_q;
    pulse_on_d    = pulse_on_q;
    pulse_off_d   = pulse_off_q;
    status_d      = 1'b0;
    bump          = 1'b0;
    case (op_e'(item_q.op))
      OpVibrate: begin
        if (shot == 16'd0 && pulses == 16'd0) begin
          status_d = 1'b1;
        end else if (shot != 16'd0) begin
          // one-shots are swallowed while a pattern runs
          if (pulses_left_q == 16'd0) begin
            phase_d       = PhShot;
            remaining_d   = sat_ms(shot_min);
            pulses_left_d = '0;
          end
          bump = 1'b1;
        end else if (pulses_left_q != 16'd0 || on_ms < MinMs || off_ms < MinMs) begin
          status_d = 1'b1;
        end else begin
          pulse_on_d    = sat_ms(on_ms);
          pulse_off_d   = sat_ms(off_ms);
          pulses_left_d = pulses;
          phase_d       = PhOn;
          remaining_d   = sat_ms(on_ms);
          bump          = 1'b1;
        end
      end
      OpCancel: begin
        phase_d       = PhIdle;
        remaining_d   = '0;
        pulses_left_d = '0;
      end
      OpTick: begin
        if (phase_q != PhIdle) begin
          remaining_d = rem_dec;
          if (rem_dec == '0) begin
            case (phase_q)
              PhShot: begin
                phase_d       = PhIdle;
                pulses_left_d = '0;
              end
              PhOn: begin
                if (pl_dec != 16'd0) begin
                  pulses_left_d = pl_dec;
                  phase_d       = PhOff;
                  remaining_d   = pulse_off_q;
                end else begin
                  phase_d       = PhIdle;
                  pulses_left_d = '0;
                end
              end
              PhOff: begin
                phase_d     = PhOn;
                remaining_d = pulse_on_q;
              end
              default: ;
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  assign effect_cnt_d = !bump ? effect_cnt_q :
                        (effect_cnt_q == IdMax) ? IdWidth'(1) : effect_cnt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhIdle;
      remaining_q   <= '0;
      pulses_left_q <= '0;
      pulse_on_q    <= '0;
      pulse_off_q   <= '0;
      effect_cnt_q  <= '0;
    end else if (commit) begin
      phase_q       <= phase_d;
      remaining_q   <= remaining_d;
      pulses_left_q <= pulses_left_d;
      pulse_on_q    <= pulse_on_d;
      pulse_off_q   <= pulse_off_d;
      effect_cnt_q  <= effect_cnt_d;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_item_q.motor_on       <= (phase_d == PhShot) || (phase_d == PhOn);
      out_item_q.status         <= status_d;
      out_item_q.effect_id      <= effect_cnt_d;
      out_item_q.pattern_active <= (phase_d == PhOn) || (phase_d == PhOff);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // ---------------- assertions ----------------
`include "haptic_pulse_pattern_sequencer_core_macros.svh"

  `HPPS_ASSERT_NOW(a_idle_no_time, clk_i, rst_ni, phase_q == PhIdle, remaining_q == '0)
  `HPPS_ASSERT_NOW(a_pulses_in_pattern, clk_i, rst_ni, pulses_left_q != 16'd0,
                   phase_q == PhOn || phase_q == PhOff)
  `HPPS_ASSERT_NEXT(a_commit_fills_out, clk_i, rst_ni, commit, out_valid_q)
  `HPPS_ASSERT_NEXT(a_id_never_zero, clk_i, rst_ni, effect_cnt_q != '0, effect_cnt_q != '0)

endmodule

`default_nettype wire

// ===== tb/hpps_motor_checker.sv =====
`timescale 1ns / 1ps
// Checker for the haptic sequencer: predicts each result and compares it on the output channel

module hpps_motor_checker
  import hpps_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  input  wire        in_ready_i,
  input  in_item_t   in_item_i,
  input  wire        out_valid_i,
  input  wire        out_ready_i,
  input  out_item_t  out_item_i,
  input  wire        cfg_we_i,
  input  wire  [2:0] cfg_idx_i,
  input  wire [15:0] cfg_wdata_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_o
);

  localparam int PrintLimit = 40;

  // register copies
  logic [15:0] tap_ms, notify_ms, alert_on_ms, alert_off_ms, ring_on_ms, ring_off_ms;
  logic [7:0]  alert_pulses, ring_pulses;

  // sequencer state
  phase_e             ph;
  logic [15:0]        remain_ms;
  logic [15:0]        pulses_left;
  logic [15:0]        on_ms;
  logic [15:0]        off_ms;
  logic [IdWidth-1:0] id_cnt;

  out_item_t predicted_results [$];
  out_item_t predicted;
  out_item_t oldest;
  int        fails;
  int        checked;

  task automatic report_mismatch(input string what, input logic [33:0] got,
                                 input logic [33:0] want);
    fails++;
    // keep the log short when the block is badly off
    if (fails <= PrintLimit) begin
      $display("mismatch: %s at result %0d, got %0h, expected %0h", what, checked, got, want);
    end
  endtask

  task automatic stop_motor();
    ph = PhIdle;
    remain_ms = '0;
    pulses_left = '0;
  endtask

  task automatic bump_id();
    if (id_cnt >= IdMax) begin
      id_cnt = IdWidth'(1);
    end else begin
      id_cnt = id_cnt + 1'b1;
    end
  endtask

  task automatic step_sequencer(input in_item_t it, output out_item_t res);
    logic [15:0] shot, pulses, on_t, off_t;
    logic        rejected;
    rejected = 1'b0;
    shot = '0;
    pulses = '0;
    on_t = '0;
    off_t = '0;
    case (it.op)
      OpVibrate: begin
        case (it.effect_type)
          EffFree: begin
            if (it.period_ms != 16'd0) begin
              pulses = it.duration_ms / it.period_ms;
              on_t = it.period_ms >> 1;
              off_t = on_t;
              if (pulses == 16'd0) shot = it.duration_ms;
            end else begin
              shot = it.duration_ms;
            end
          end
          EffTapUp, EffTapDown: shot = tap_ms;
          EffNotify: shot = notify_ms;
          EffAlert: begin
            pulses = {8'd0, alert_pulses};
            on_t = alert_on_ms;
            off_t = alert_off_ms;
          end
          EffRing: begin
            pulses = {8'd0, ring_pulses};
            on_t = ring_on_ms;
            off_t = ring_off_ms;
          end
          default: ;
        endcase
        if (shot == 16'd0 && pulses == 16'd0) begin
          rejected = 1'b1;
        end else if (shot != 16'd0) begin
          if (shot < MinMs) shot = MinMs;
          // swallow the one-shot while a pattern runs
          if (pulses_left == 16'd0) begin
            ph = PhShot;
            remain_ms = shot;
          end
          bump_id();
        end else if (pulses_left != 16'd0 || on_t < MinMs || off_t < MinMs) begin
          rejected = 1'b1;
        end else begin
          on_ms = on_t;
          off_ms = off_t;
          pulses_left = pulses;
          ph = PhOn;
          remain_ms = on_t;
          bump_id();
        end
      end
      OpCancel: stop_motor();
      OpTick: begin
        if (ph != PhIdle) begin
          if (remain_ms != 16'd0) remain_ms = remain_ms - 1'b1;
          if (remain_ms == 16'd0) begin
            case (ph)
              PhShot: stop_motor();
              PhOn: begin
                if (pulses_left != 16'd0) pulses_left = pulses_left - 1'b1;
                if (pulses_left != 16'd0) begin
                  ph = PhOff;
                  remain_ms = off_ms;
                end else begin
                  stop_motor();
                end
              end
              default: begin
                ph = PhOn;
                remain_ms = on_ms;
              end
            endcase
          end
        end
      end
      default: ;
    endcase
    res.motor_on = (ph == PhShot || ph == PhOn);
    res.status = rejected;
    res.effect_id = id_cnt;
    res.pattern_active = (ph == PhOn || ph == PhOff);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_ms = 16'd50;
      notify_ms = 16'd300;
      alert_pulses = 8'd3;
      alert_on_ms = 16'd500;
      alert_off_ms = 16'd500;
      ring_pulses = 8'd4;
      ring_on_ms = 16'd800;
      ring_off_ms = 16'd400;
      stop_motor();
      on_ms = '0;
      off_ms = '0;
      id_cnt = '0;
      predicted_results.delete();
      fails = 0;
      checked = 0;
      fail_count_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgTapMs:       tap_ms = cfg_wdata_i;
          CfgNotifyMs:    notify_ms = cfg_wdata_i;
          CfgAlertPulses: alert_pulses = cfg_wdata_i[7:0];
          CfgAlertOnMs:   alert_on_ms = cfg_wdata_i;
          CfgAlertOffMs:  alert_off_ms = cfg_wdata_i;
          CfgRingPulses:  ring_pulses = cfg_wdata_i[7:0];
          CfgRingOnMs:    ring_on_ms = cfg_wdata_i;
          CfgRingOffMs:   ring_off_ms = cfg_wdata_i;
          default: ;
        endcase
      end
      // push before pop so a same-cycle pair keeps its order
      if (in_valid_i && in_ready_i) begin
        step_sequencer(in_item_i, predicted);
        predicted_results.push_back(predicted);
      end
      if (out_valid_i && out_ready_i) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("result with nothing expected", out_item_i, '0);
        end else begin
          oldest = predicted_results.pop_front();
          if (out_item_i.motor_on != oldest.motor_on)
            report_mismatch("motor_on", out_item_i.motor_on, oldest.motor_on);
          if (out_item_i.status != oldest.status)
            report_mismatch("status", out_item_i.status, oldest.status);
          if (out_item_i.effect_id != oldest.effect_id)
            report_mismatch("effect_id", out_item_i.effect_id, oldest.effect_id);
          if (out_item_i.pattern_active != oldest.pattern_active)
            report_mismatch("pattern_active", out_item_i.pattern_active,
                            oldest.pattern_active);
          checked++;
        end
      end
      fail_count_o <= fails;
      pending_o <= predicted_results.size();
      checked_o <= checked;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the haptic sequencer: clock, reset, stimulus, output stalls and verdict

module tb_top;
  import hpps_pkg::*;

  localparam logic [1:0] OpUnused     = 2'd3;
  localparam logic [2:0] EffInvalidLo = 3'd6;
  localparam logic [2:0] EffInvalidHi = 3'd7;

  localparam int PhaseItems   = 412;
  localparam int HoldCycles   = 400;
  localparam int SettleCycles = 40;
  localparam int StallLimit   = 5000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [15:0] cfg_wdata;

  int fail_count;
  int pending;
  int checked;
  int items_sent;
  int settings_used;
  int stall_cycles;

  bit hold_req;
  bit hold_done;

  logic [15:0] cfg_next [8];

  always #10 clk = ~clk;

  haptic_pulse_pattern_sequencer_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  hpps_motor_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // end the run if nothing moves on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("timeout: no item moved for %0d cycles", stall_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: changing stall patterns, plus one long hold-off on request
  initial begin : receiver
    int mode;
    int seg;
    int cyc;
    mode = 0;
    seg = 0;
    cyc = 0;
    out_ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        if (seg == 0) begin
          mode = $urandom_range(0, 3);
          seg = $urandom_range(16, 96);
        end
        seg--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (cyc % 3 != 0);
        endcase
      end
    end
  end

  function automatic in_item_t mk(input logic [1:0] op, input logic [2:0] eff,
                                  input logic [15:0] dur, input logic [15:0] per);
    in_item_t it;
    it.op = op;
    it.effect_type = eff;
    it.duration_ms = dur;
    it.period_ms = per;
    return it;
  endfunction

  // mostly ticks and well-formed requests; the remaining fields stay random
  function automatic in_item_t rand_item();
    in_item_t it;
    int pick;
    int per;
    it.op = OpTick;
    it.effect_type = 3'($urandom);
    it.duration_ms = 16'($urandom);
    it.period_ms = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      it.op = OpTick;
    end else if (pick < 65) begin
      it.op = OpCancel;
    end else if (pick < 67) begin
      it.op = OpUnused;
    end else begin
      it.op = OpVibrate;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        it.effect_type = 3'($urandom_range(EffInvalidLo, EffInvalidHi));
      end else if (pick < 45) begin
        it.effect_type = 3'($urandom_range(EffTapUp, EffRing));
      end else begin
        it.effect_type = EffFree;
        case ($urandom_range(0, 4))
          0: begin
            it.period_ms = 16'd0;
            it.duration_ms = 16'($urandom_range(0, 160));
          end
          1: begin
            per = $urandom_range(100, 240);
            it.period_ms = 16'(per);
            it.duration_ms = 16'(per * $urandom_range(0, 4) + $urandom_range(0, per - 1));
          end
          2: begin
            it.period_ms = 16'($urandom_range(1, 99));
            it.duration_ms = 16'($urandom_range(0, 800));
          end
          default: ;
        endcase
      end
    end
    return it;
  endfunction

  // valid stays high from one item to the next until a gap lowers it
  task automatic send_item(input in_item_t it);
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic apply_settings();
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_idx <= i[2:0];
      cfg_wdata <= cfg_next[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic pick_settings(input int p);
    case (p)
      0: begin
        cfg_next[CfgTapMs] = 16'd1;
        cfg_next[CfgNotifyMs] = 16'd65535;
        cfg_next[CfgAlertPulses] = 16'd1;
        cfg_next[CfgAlertOnMs] = 16'd50;
        cfg_next[CfgAlertOffMs] = 16'd50;
        cfg_next[CfgRingPulses] = 16'd255;
        cfg_next[CfgRingOnMs] = 16'd50;
        cfg_next[CfgRingOffMs] = 16'd50;
      end
      1: begin
        cfg_next[CfgTapMs] = 16'd65535;
        cfg_next[CfgNotifyMs] = 16'd49;
        cfg_next[CfgAlertPulses] = 16'd2;
        cfg_next[CfgAlertOnMs] = 16'd51;
        cfg_next[CfgAlertOffMs] = 16'd65535;
        cfg_next[CfgRingPulses] = 16'd1;
        cfg_next[CfgRingOnMs] = 16'd65535;
        cfg_next[CfgRingOffMs] = 16'd50;
      end
      default: begin
        cfg_next[CfgTapMs] = 16'($urandom_range(1, 150));
        cfg_next[CfgNotifyMs] = 16'($urandom_range(1, 150));
        cfg_next[CfgAlertPulses] = 16'($urandom_range(1, 6));
        cfg_next[CfgAlertOnMs] = 16'($urandom_range(50, 120));
        cfg_next[CfgAlertOffMs] = 16'($urandom_range(50, 120));
        cfg_next[CfgRingPulses] = 16'($urandom_range(1, 6));
        cfg_next[CfgRingOnMs] = 16'($urandom_range(50, 120));
        cfg_next[CfgRingOffMs] = 16'($urandom_range(50, 120));
      end
    endcase
  endtask

  initial begin : stimulus
    int n;
    int burst;
    bit paused;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    hold_req = 1'b0;
    items_sent = 0;
    settings_used = 0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part at reset settings
    send_item(mk(OpTick, EffFree, 16'd0, 16'd0));
    send_item(mk(OpUnused, EffInvalidHi, 16'hFFFF, 16'hFFFF));
    send_item(mk(OpVibrate, EffInvalidLo, 16'd100, 16'd0));
    send_item(mk(OpVibrate, EffInvalidHi, 16'hFFFF, 16'hFFFF));
    send_item(mk(OpVibrate, EffFree, 16'd0, 16'd0));
    send_item(mk(OpVibrate, EffFree, 16'd0, 16'hFFFF));
    send_item(mk(OpVibrate, EffFree, 16'd10, 16'd0));
    send_item(mk(OpTick, EffRing, 16'hFFFF, 16'hFFFF));
    send_item(mk(OpVibrate, EffTapUp, 16'd0, 16'd0));
    send_item(mk(OpVibrate, EffTapDown, 16'hFFFF, 16'hFFFF));
    send_item(mk(OpVibrate, EffNotify, 16'd0, 16'd0));
    send_item(mk(OpVibrate, EffAlert, 16'd0, 16'd0));
    send_item(mk(OpVibrate, EffRing, 16'd0, 16'd0));
    send_item(mk(OpVibrate, EffTapUp, 16'd0, 16'd0));
    send_item(mk(OpTick, EffFree, 16'd0, 16'd0));
    send_item(mk(OpCancel, EffAlert, 16'hFFFF, 16'hFFFF));
    send_item(mk(OpVibrate, EffFree, 16'd400, 16'd40));
    send_item(mk(OpVibrate, EffFree, 16'd50, 16'd100));
    send_item(mk(OpVibrate, EffFree, 16'hFFFF, 16'hFFFF));
    send_item(mk(OpCancel, EffFree, 16'd0, 16'd0));
    send_item(mk(OpVibrate, EffFree, 16'hFFFF, 16'd1));
    send_item(mk(OpVibrate, EffFree, 16'd300, 16'd100));
    send_item(mk(OpTick, EffFree, 16'd0, 16'd0));
    send_item(mk(OpCancel, EffFree, 16'd0, 16'd0));
    send_item(mk(OpTick, EffFree, 16'd0, 16'd0));
    drain();

    for (int p = 0; p < 4; p++) begin
      pick_settings(p);
      apply_settings();
      n = 0;
      paused = 1'b0;
      while (n < PhaseItems) begin
        // long output hold-off while items keep coming, once
        if (p == 1 && n >= 40) hold_req = 1'b1;
        // let everything drain mid-phase, once
        if (p == 2 && !paused && n >= 200) begin
          drain();
          paused = 1'b1;
        end
        burst = $urandom_range(1, 24);
        if (burst > PhaseItems - n) burst = PhaseItems - n;
        repeat (burst) begin
          send_item(rand_item());
          n++;
        end
        if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 12));
      end
      drain();
    end

    $display("sent %0d items under reset and %0d written register settings, %0d results checked",
             items_sent, settings_used, checked);
    $display("covered one-shots, pulse trains, rejects, cancels, ticks, a long output hold and a drain");
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
